[sv/esp_pkg.sv]
// Package: shared constants, character classes and queue entry type for the expression PDA.
`default_nettype none

package esp_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam int CH_W = 8;

    localparam logic [CH_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CH_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [CH_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CH_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;

    typedef logic [2:0] cls_t;

    localparam cls_t CLS_OTHER  = 3'd0;
    localparam cls_t CLS_DOLLAR = 3'd1;
    localparam cls_t CLS_LPAREN = 3'd2;
    localparam cls_t CLS_RPAREN = 3'd3;
    localparam cls_t CLS_OP     = 3'd4;
    localparam cls_t CLS_DIGIT  = 3'd5;
    localparam cls_t CLS_ALPHA  = 3'd6;

    typedef struct packed {
        cls_t cls;
        logic last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

`default_nettype wire

[sv/esp_ifs.sv]
// Interfaces: character request channel and verdict channel.
`default_nettype none

interface esp_char_if;
    logic                     valid;
    logic                     ready;
    logic [esp_pkg::CH_W-1:0] ch;
    logic                     last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface esp_verdict_if;
    logic valid;
    logic ready;
    logic accepted;
    logic crashed;

    modport source (output valid, output accepted, output crashed, input ready);
    modport sink   (input valid, input accepted, input crashed, output ready);
endinterface

`default_nettype wire

[sv/esp_front.sv]
// Front end: accepts characters and classifies them into queue entries.
`default_nettype none

module esp_front
(
    esp_char_if.sink        chars,
    input  wire logic       q_ready,
    output logic            q_push,
    output esp_pkg::item_t  q_item
);

    esp_pkg::cls_t cls;

    always_comb
    begin
        unique case (chars.ch) inside
            esp_pkg::CH_DOLLAR:                          cls = esp_pkg::CLS_DOLLAR;
            esp_pkg::CH_LPAREN:                          cls = esp_pkg::CLS_LPAREN;
            esp_pkg::CH_RPAREN:                          cls = esp_pkg::CLS_RPAREN;
            esp_pkg::CH_PLUS, esp_pkg::CH_MINUS,
            esp_pkg::CH_STAR, esp_pkg::CH_SLASH:         cls = esp_pkg::CLS_OP;
            [esp_pkg::CH_ZERO:esp_pkg::CH_NINE]:         cls = esp_pkg::CLS_DIGIT;
            [esp_pkg::CH_UPPER_A:esp_pkg::CH_UPPER_Z],
            [esp_pkg::CH_LOWER_A:esp_pkg::CH_LOWER_Z],
            esp_pkg::CH_UNDER:                           cls = esp_pkg::CLS_ALPHA;
            default:                                     cls = esp_pkg::CLS_OTHER;
        endcase
    end

    assign chars.ready = q_ready;
    assign q_push      = chars.valid && q_ready;
    assign q_item.cls  = cls;
    assign q_item.last = chars.last;

endmodule

`default_nettype wire

[sv/esp_queue.sv]
// Queue: small register FIFO of classified characters between front and back.
`default_nettype none

module esp_queue
#(
    parameter int DEPTH = esp_pkg::QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire esp_pkg::item_t        push_item,
    output logic                       push_ready,
    input  wire logic                  pop,
    output esp_pkg::queue_head_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    esp_pkg::item_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[sv/esp_back.sv]
// Back end: pushdown automaton, mark stack level and verdict output register.
`default_nettype none

module esp_back
#(
    parameter int STACK_DEPTH = esp_pkg::STACK_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire esp_pkg::queue_head_t  head,
    output logic                       pop,
    esp_verdict_if.source              verdicts
);

    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] PH_Q1 = 3'd0;
    localparam logic [2:0] PH_Q2 = 3'd1;
    localparam logic [2:0] PH_Q3 = 3'd2;
    localparam logic [2:0] PH_Q4 = 3'd3;
    localparam logic [2:0] PH_Q5 = 3'd4;
    localparam logic [2:0] PH_Q6 = 3'd5;

    logic [2:0]         phase_reg, phase_next;
    logic               dead_reg, dead_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               out_valid_reg, out_valid_next;
    logic               accepted_reg, accepted_next;
    logic               crashed_reg, crashed_next;

    logic       top_dollar;
    logic       top_paren;
    logic       ok;
    logic       do_push;
    logic       do_pop;
    logic       overflow;
    logic [2:0] target;
    logic [2:0] phase_step;
    logic       dead_step;
    logic [LEVEL_W-1:0] level_step;
    esp_pkg::cls_t cls;

    // The only dollar mark sits at the bottom; every mark above it is a paren.
    assign top_dollar = (level_reg == LEVEL_W'(1));
    assign top_paren  = (level_reg > LEVEL_W'(1));
    assign cls        = head.item.cls;

    assign pop = head.valid && (!head.item.last || !out_valid_reg || verdicts.ready);

    always_comb
    begin
        ok      = 1'b1;
        do_push = 1'b0;
        do_pop  = 1'b0;
        target  = phase_reg;
        unique case (phase_reg) inside
            PH_Q1:
            begin
                if (cls == esp_pkg::CLS_DOLLAR)
                begin
                    do_push = 1'b1;
                    target  = PH_Q2;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            PH_Q2:
            begin
                if (cls == esp_pkg::CLS_LPAREN)
                begin
                    do_push = 1'b1;
                    target  = PH_Q2;
                end
                else if (cls == esp_pkg::CLS_DIGIT)
                begin
                    target = PH_Q3;
                end
                else if (cls == esp_pkg::CLS_ALPHA)
                begin
                    target = PH_Q4;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            PH_Q3, PH_Q4, PH_Q5:
            begin
                if (cls == esp_pkg::CLS_DOLLAR && top_dollar)
                begin
                    do_pop = 1'b1;
                    target = PH_Q6;
                end
                else if (cls == esp_pkg::CLS_RPAREN && top_paren)
                begin
                    do_pop = 1'b1;
                    target = PH_Q5;
                end
                else if (cls == esp_pkg::CLS_OP)
                begin
                    target = PH_Q2;
                end
                else if (phase_reg == PH_Q3 && cls == esp_pkg::CLS_DIGIT)
                begin
                    target = PH_Q3;
                end
                else if (phase_reg == PH_Q4
                         && (cls == esp_pkg::CLS_ALPHA || cls == esp_pkg::CLS_DIGIT))
                begin
                    target = PH_Q4;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign overflow = do_push && (level_reg == LEVEL_W'(STACK_DEPTH));

    always_comb
    begin
        phase_step = phase_reg;
        dead_step  = dead_reg;
        level_step = level_reg;
        if (!dead_reg)
        begin
            if (!ok || overflow)
            begin
                dead_step = 1'b1;
            end
            else
            begin
                phase_step = target;
            end
            if (do_push && !overflow)
            begin
                level_step = level_reg + LEVEL_W'(1);
            end
            if (do_pop)
            begin
                level_step = level_reg - LEVEL_W'(1);
            end
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        dead_next      = dead_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg && !verdicts.ready;
        accepted_next  = accepted_reg;
        crashed_next   = crashed_reg;
        if (pop)
        begin
            if (head.item.last)
            begin
                out_valid_next = 1'b1;
                accepted_next  = !dead_step && (phase_step == PH_Q6);
                crashed_next   = dead_step;
                phase_next     = PH_Q1;
                dead_next      = 1'b0;
                level_next     = '0;
            end
            else
            begin
                phase_next = phase_step;
                dead_next  = dead_step;
                level_next = level_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_Q1;
            dead_reg      <= 1'b0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            dead_reg      <= dead_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        crashed_reg  <= crashed_next;
    end

    assign verdicts.valid    = out_valid_reg;
    assign verdicts.accepted = accepted_reg;
    assign verdicts.crashed  = crashed_reg;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_W'(STACK_DEPTH))
        else $error("mark stack level beyond depth");

    a_q1_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_Q1 |-> level_reg == '0)
        else $error("stack not empty in start phase");

    a_q6_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_Q6 |-> level_reg == '0)
        else $error("stack not empty after closing marker");

    a_verdict_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(accepted_reg && crashed_reg))
        else $error("verdict both accepted and crashed");

    a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.item.last |=> out_valid_reg)
        else $error("final character gave no verdict");

endmodule

`default_nettype wire

[sv/expression_syntax_pda_core.sv]
// Top level: expression syntax pushdown recognizer with decoupled front and back ends.
//
//   channel   modport   payload                 meaning
//   chars     sink      ch[7:0], last           one character request per handshake
//   verdicts  source    accepted, crashed       one verdict per final character
//
// Unless stalled, one character enters and the back end retires one entry per cycle.
// A verdict is registered at the edge where its final character leaves the queue,
// at the earliest the edge after that character is accepted.
// The back end stalls only on a final character while an earlier verdict waits.
// The QUEUE_DEPTH entry queue absorbs such stalls before chars.ready drops.
// Reset clears phase, crash flag, stack level and queue; no clearing pass.
`default_nettype none

module expression_syntax_pda_core
#(
    parameter int STACK_DEPTH = esp_pkg::STACK_DEPTH,
    parameter int QUEUE_DEPTH = esp_pkg::QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    esp_char_if.sink        chars,
    esp_verdict_if.source   verdicts
);

    logic                  q_push;
    logic                  q_ready;
    logic                  q_pop;
    esp_pkg::item_t        q_item;
    esp_pkg::queue_head_t  q_head;

    esp_front u_front
    (
        .chars   (chars),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_item  (q_item)
    );

    esp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head       (q_head)
    );

    esp_back
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .pop      (q_pop),
        .verdicts (verdicts)
    );

endmodule

`default_nettype wire

[bench/testbench.sv]
// Testbench: expression syntax recognizer checked verdict by verdict against a directed table and its own predictor.
`timescale 1ns / 1ps

module testbench;

    typedef enum logic [2:0] {
        PH_START,
        PH_OPERAND,
        PH_NUMBER,
        PH_NAME,
        PH_CLOSED,
        PH_DONE
    } pda_phase_t;

    typedef enum logic [1:0] {
        MARK_NONE,
        MARK_DOLLAR,
        MARK_PAREN
    } top_mark_t;

    typedef struct packed {
        logic accepted;
        logic crashed;
    } verdict_t;

    typedef struct {
        logic [esp_pkg::CH_W-1:0] ch;
        logic                     last;
        verdict_t                 verdict;
    } directed_row_t;

    localparam int RANDOM_CHARS  = 1700;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 40;
    localparam int DRAIN_CYCLES  = 8;

    logic clk = 1'b0;
    logic rst_n;

    esp_char_if    char_bus();
    esp_verdict_if verdict_bus();

    expression_syntax_pda_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (char_bus),
        .verdicts (verdict_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state
    pda_phase_t     parse_phase;
    bit             parse_dead;
    bit             paren_marks [esp_pkg::STACK_DEPTH];
    int             mark_level;

    verdict_t       expected_verdicts [$];
    logic [7:0]     text [$];
    int             mismatches;
    int             verdicts_seen;
    int             sent_chars;
    bit             steady;

    // '{ch, last, '{accepted, crashed}}; verdicts only matter on the final character
    directed_row_t directed_rows [26] = '{
        '{"$", 1'b0, 2'b00}, '{"a", 1'b0, 2'b00}, '{"$", 1'b1, 2'b10},
        '{"$", 1'b0, 2'b00}, '{"9", 1'b0, 2'b00}, '{"/", 1'b0, 2'b00},
        '{")", 1'b1, 2'b01},
        '{"$", 1'b0, 2'b00}, '{"(", 1'b0, 2'b00}, '{"_", 1'b0, 2'b00},
        '{")", 1'b0, 2'b00}, '{"$", 1'b1, 2'b10},
        '{8'hFF, 1'b1, 2'b01},
        '{8'h00, 1'b1, 2'b01},
        '{"$", 1'b0, 2'b00}, '{"1", 1'b0, 2'b00}, '{"$", 1'b0, 2'b00},
        '{"+", 1'b1, 2'b01},
        '{"$", 1'b0, 2'b00}, '{"0", 1'b0, 2'b00}, '{"-", 1'b1, 2'b00},
        '{"$", 1'b0, 2'b00}, '{"z", 1'b0, 2'b00}, '{"*", 1'b0, 2'b00},
        '{"9", 1'b0, 2'b00}, '{"$", 1'b1, 2'b10}
    };

    function automatic void push_mark(input bit paren);
        if (mark_level >= esp_pkg::STACK_DEPTH)
            parse_dead = 1'b1;
        else
        begin
            paren_marks[mark_level] = paren;
            mark_level++;
        end
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic fin,
                                       output verdict_t v);
        bit         is_dig;
        bit         is_let;
        bit         is_opr;
        bit         ok;
        top_mark_t  top;
        pda_phase_t nxt;

        v = '0;
        if (!parse_dead)
        begin
            is_dig = (c >= esp_pkg::CH_ZERO && c <= esp_pkg::CH_NINE);
            is_let = (c >= esp_pkg::CH_LOWER_A && c <= esp_pkg::CH_LOWER_Z) ||
                     (c >= esp_pkg::CH_UPPER_A && c <= esp_pkg::CH_UPPER_Z);
            is_opr = (c == esp_pkg::CH_PLUS || c == esp_pkg::CH_MINUS ||
                      c == esp_pkg::CH_STAR || c == esp_pkg::CH_SLASH);
            top = MARK_NONE;
            if (mark_level > 0)
                top = paren_marks[mark_level-1] ? MARK_PAREN : MARK_DOLLAR;
            nxt = parse_phase;
            ok = 1'b1;
            case (parse_phase)
                PH_START:
                    if (c == esp_pkg::CH_DOLLAR)
                    begin
                        push_mark(1'b0);
                        nxt = PH_OPERAND;
                    end
                    else
                        ok = 1'b0;
                PH_OPERAND:
                    if (c == esp_pkg::CH_LPAREN)
                        push_mark(1'b1);
                    else if (is_dig)
                        nxt = PH_NUMBER;
                    else if (is_let || c == esp_pkg::CH_UNDER)
                        nxt = PH_NAME;
                    else
                        ok = 1'b0;
                PH_NUMBER, PH_NAME, PH_CLOSED:
                    if (c == esp_pkg::CH_DOLLAR && top == MARK_DOLLAR)
                    begin
                        mark_level--;
                        nxt = PH_DONE;
                    end
                    else if (c == esp_pkg::CH_RPAREN && top == MARK_PAREN)
                    begin
                        mark_level--;
                        nxt = PH_CLOSED;
                    end
                    else if (is_opr)
                        nxt = PH_OPERAND;
                    else if (parse_phase == PH_NUMBER && is_dig)
                        nxt = PH_NUMBER;
                    else if (parse_phase == PH_NAME
                             && (is_let || is_dig || c == esp_pkg::CH_UNDER))
                        nxt = PH_NAME;
                    else
                        ok = 1'b0;
                default:
                    ok = 1'b0;
            endcase
            if (!ok)
                parse_dead = 1'b1;
            else if (!parse_dead)
                parse_phase = nxt;
        end
        if (fin)
        begin
            v.accepted  = !parse_dead && parse_phase == PH_DONE;
            v.crashed   = parse_dead;
            parse_phase = PH_START;
            parse_dead  = 1'b0;
            mark_level  = 0;
        end
    endfunction

    // Entered and left at a falling edge
    task automatic send_char(input logic [7:0] c, input logic fin,
                             input bit typed, input verdict_t typed_verdict);
        verdict_t v;

        while (!steady && $urandom_range(0, 99) < 15)
        begin
            char_bus.valid <= 1'b0;
            @(negedge clk);
        end
        char_bus.valid <= 1'b1;
        char_bus.ch    <= c;
        char_bus.last  <= fin;
        do
            @(posedge clk);
        while (!char_bus.ready);
        parse_char(c, fin, v);
        sent_chars++;
        if (fin)
            expected_verdicts.push_back(typed ? typed_verdict : v);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1))
            return 8'(esp_pkg::CH_LOWER_A + $urandom_range(0, 25));
        return 8'(esp_pkg::CH_UPPER_A + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return esp_pkg::CH_PLUS;
            1:       return esp_pkg::CH_MINUS;
            2:       return esp_pkg::CH_STAR;
            default: return esp_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 7))
            0:       return esp_pkg::CH_DOLLAR;
            1:       return esp_pkg::CH_LPAREN;
            2:       return esp_pkg::CH_RPAREN;
            3:       return pick_operator();
            4:       return esp_pkg::CH_UNDER;
            5:       return 8'(esp_pkg::CH_ZERO + $urandom_range(0, 9));
            6:       return pick_letter();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_operand();
        int n;

        n = $urandom_range(0, 4);
        if ($urandom_range(0, 1))
        begin
            text.push_back(8'(esp_pkg::CH_ZERO + $urandom_range(0, 9)));
            repeat (n) text.push_back(8'(esp_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
        else
        begin
            text.push_back($urandom_range(0, 5) == 0 ? esp_pkg::CH_UNDER : pick_letter());
            repeat (n)
                case ($urandom_range(0, 2))
                    0:       text.push_back(pick_letter());
                    1:       text.push_back(8'(esp_pkg::CH_ZERO + $urandom_range(0, 9)));
                    default: text.push_back(esp_pkg::CH_UNDER);
                endcase
        end
    endfunction

    function automatic void build_expression();
        int terms;
        int opens;

        text.delete();
        text.push_back(esp_pkg::CH_DOLLAR);
        opens = 0;
        terms = $urandom_range(1, 5);
        for (int t = 0; t < terms; t++)
        begin
            while (opens < 3 && $urandom_range(0, 3) == 0)
            begin
                text.push_back(esp_pkg::CH_LPAREN);
                opens++;
            end
            add_operand();
            while (opens > 0 && $urandom_range(0, 2) == 0)
            begin
                text.push_back(esp_pkg::CH_RPAREN);
                opens--;
            end
            if (t < terms - 1)
                text.push_back(pick_operator());
        end
        repeat (opens) text.push_back(esp_pkg::CH_RPAREN);
        text.push_back(esp_pkg::CH_DOLLAR);
    endfunction

    function automatic void build_nesting();
        int depth;

        text.delete();
        depth = $urandom_range(esp_pkg::STACK_DEPTH - 4, esp_pkg::STACK_DEPTH + 2);
        text.push_back(esp_pkg::CH_DOLLAR);
        repeat (depth) text.push_back(esp_pkg::CH_LPAREN);
        add_operand();
        repeat (depth) text.push_back(esp_pkg::CH_RPAREN);
        text.push_back(esp_pkg::CH_DOLLAR);
    endfunction

    function automatic void build_string();
        int kind;
        int n;

        kind = $urandom_range(0, 99);
        if (kind < 65)
            build_expression();
        else if (kind < 77)
        begin
            build_expression();
            n = $urandom_range(0, text.size() - 1);
            text[n] = $urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255));
        end
        else if (kind < 81)
            build_nesting();
        else if (kind < 86)
        begin
            build_expression();
            n = $urandom_range(1, 3);
            while (n > 0 && text.size() > 1)
            begin
                void'(text.pop_back());
                n--;
            end
        end
        else if (kind < 91)
        begin
            build_expression();
            text.push_back(pick_special());
        end
        else
        begin
            text.delete();
            n = $urandom_range(1, 5);
            repeat (n)
                text.push_back($urandom_range(0, 1) ? pick_special()
                                                   : 8'($urandom_range(0, 255)));
        end
    endfunction

    // Verdict receiver
    initial
    begin
        int  hold_left;
        bit  held;

        hold_left = 0;
        held = 1'b0;
        verdict_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && verdicts_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                verdict_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                verdict_bus.ready <= steady || $urandom_range(0, 99) >= 15;
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;

        if (rst_n && verdict_bus.valid && verdict_bus.ready)
        begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0)
            begin
                $error("verdict with none expected: accepted %0b crashed %0b",
                       verdict_bus.accepted, verdict_bus.crashed);
                mismatches++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (verdict_bus.accepted !== want.accepted)
                begin
                    $error("accepted: expected %0b, actual %0b",
                           want.accepted, verdict_bus.accepted);
                    mismatches++;
                end
                if (verdict_bus.crashed !== want.crashed)
                begin
                    $error("crashed: expected %0b, actual %0b",
                           want.crashed, verdict_bus.crashed);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        int strings_sent;

        parse_phase    = PH_START;
        parse_dead     = 1'b0;
        mark_level     = 0;
        mismatches     = 0;
        verdicts_seen  = 0;
        sent_chars     = 0;
        steady         = 1'b0;
        strings_sent   = 0;
        char_bus.valid = 1'b0;
        char_bus.ch    = '0;
        char_bus.last  = 1'b0;
        rst_n          = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_char(directed_rows[i].ch, directed_rows[i].last, 1'b1,
                      directed_rows[i].verdict);

        sent_chars = 0;
        while (sent_chars < RANDOM_CHARS)
        begin
            steady = (strings_sent >= 120 && strings_sent < 180);
            build_string();
            foreach (text[i])
                send_char(text[i], i == text.size() - 1, 1'b0, '0);
            strings_sent++;
        end
        steady = 1'b0;
        char_bus.valid <= 1'b0;

        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
